FILE: hw/rtl/sit_pkg.sv
// Package for the sorted interval table: widths, codes and the cell record.
// Used by sit_cell, sit_chain and sorted_interval_table; depends on nothing.
package sit_pkg;
    localparam int DEPTH     = 64;
    localparam int TIME_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int TAG_BITS  = 16;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_INSERT  = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_REPLACE = 3'd3;
    localparam logic [2:0] CMD_LOOKUP  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_INDEX = 3'd2;
    localparam logic [2:0] ST_UNCHANGED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [TIME_BITS-1:0] start_ms;
        logic [TIME_BITS-1:0] end_ms;
        logic [TAG_BITS-1:0]  tag;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD   = 3'b001,
        OP_OPEN   = 3'b010,  // shift up from the insert point, write new entry there
        OP_CLOSE  = 3'b100   // shift down from the removed position
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [IDX_BITS-1:0] pos;
        t_entry          entry;
    } t_ctl;
endpackage

FILE: hw/rtl/sit_cell.sv
// One table cell: holds an entry and compares it with the broadcast times.
// Depends on sit_pkg.
module sit_cell (
    input  logic                          i_clk,
    input  logic [sit_pkg::IDX_BITS-1:0]  i_my_idx,
    input  sit_pkg::t_ctl                 i_ctl,
    input  sit_pkg::t_entry               i_from_below,
    input  sit_pkg::t_entry               i_from_above,
    input  logic [sit_pkg::TIME_BITS-1:0] i_key,
    output sit_pkg::t_entry               o_entry,
    output logic                          o_start_le,
    output logic                          o_end_ge
);
    sit_pkg::t_entry r_entry;
    sit_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            sit_pkg::OP_OPEN: begin
                if (i_my_idx == i_ctl.pos) n_entry = i_ctl.entry;
                else if (i_my_idx > i_ctl.pos) n_entry = i_from_below;
            end
            sit_pkg::OP_CLOSE: begin
                if (i_my_idx >= i_ctl.pos) n_entry = i_from_above;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry    = r_entry;
    assign o_start_le = r_entry.start_ms <= i_key;
    assign o_end_ge   = r_entry.end_ms >= i_key;
endmodule

FILE: hw/rtl/sit_chain.sv
// Row of DEPTH cells with neighbor links; returns per-cell compare flags.
// Depends on sit_pkg and sit_cell.
module sit_chain (
    input  logic                          i_clk,
    input  sit_pkg::t_ctl                 i_ctl,
    input  logic [sit_pkg::TIME_BITS-1:0] i_key,
    output sit_pkg::t_entry               o_entries [sit_pkg::DEPTH],
    output logic [sit_pkg::DEPTH-1:0]     o_start_le,
    output logic [sit_pkg::DEPTH-1:0]     o_end_ge
);
    for (genvar g = 0; g < sit_pkg::DEPTH; g++) begin : g_cell
        sit_pkg::t_entry w_below;
        sit_pkg::t_entry w_above;
        if (g == 0) begin : g_lo
            assign w_below = o_entries[g];
        end else begin : g_lo_n
            assign w_below = o_entries[g-1];
        end
        if (g == sit_pkg::DEPTH - 1) begin : g_hi
            assign w_above = o_entries[g];
        end else begin : g_hi_n
            assign w_above = o_entries[g+1];
        end
        sit_cell u_cell (
            .i_clk       (i_clk),
            .i_my_idx    (sit_pkg::IDX_BITS'(g)),
            .i_ctl       (i_ctl),
            .i_from_below(w_below),
            .i_from_above(w_above),
            .i_key       (i_key),
            .o_entry     (o_entries[g]),
            .o_start_le  (o_start_le[g]),
            .o_end_ge    (o_end_ge[g])
        );
    end
endmodule

FILE: hw/rtl/sorted_interval_table.sv
// Sorted interval table: entries kept in start order in a row of cells.
// Each accepted item is evaluated in S_EVAL, which registers its result and sets
// m_axis_tvalid; a changed replace closes in S_EVAL, then opens and does so in S_REINS.
// A new item is taken only after accept, evaluate and done (and reinsert for a changed
// replace) are through; a result left waiting on m_axis_tready holds off the next item.
// Reset (sync, active low) empties the table and clears the modified flag.
module sorted_interval_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0], index[8:3], start_ms[40:9], end_ms[72:41], tag[88:73], query_ms[120:89]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], position[8:3], found_start[40:9], found_end[72:41],
    // found_tag[88:73], entry_count[95:89], modified[96]
    output logic [103:0] m_axis_tdata
);
    localparam int TB = sit_pkg::TIME_BITS;
    localparam int IB = sit_pkg::IDX_BITS;
    localparam int CB = sit_pkg::CNT_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,  // flags of the chain valid for the latched item
        S_REINS = 5'b00100,  // after a close: compute insert point of new entry
        S_DONE  = 5'b01000,  // result registered, returns to S_IDLE
        S_OUT   = 5'b10000   // unused spare drain state
    } t_state;

    t_state r_state, n_state;

    // latched item
    logic [2:0]      r_cmd;
    logic [IB-1:0]   r_idx;
    sit_pkg::t_entry r_new;
    logic [TB-1:0]   r_query;

    logic [CB-1:0]   r_count, n_count;
    logic            r_mod, n_mod;

    // result
    logic            r_ovalid;
    logic [2:0]      r_status, n_status;
    logic [IB-1:0]   r_pos, n_pos;
    sit_pkg::t_entry r_found, n_found;
    logic            n_load;

    sit_pkg::t_ctl   w_ctl;
    logic [TB-1:0]   w_key;
    sit_pkg::t_entry w_entries [sit_pkg::DEPTH];
    logic [sit_pkg::DEPTH-1:0] w_sle, w_ege;

    // valid mask over the occupied cells
    logic [sit_pkg::DEPTH-1:0] w_live;
    always_comb begin
        for (int i = 0; i < sit_pkg::DEPTH; i++) w_live[i] = CB'(i) < r_count;
    end

    // insert point: number of live entries with start <= new start (table is sorted)
    logic [CB-1:0] w_ins;
    always_comb begin
        w_ins = '0;
        for (int i = 0; i < sit_pkg::DEPTH; i++)
            if (w_live[i] && w_sle[i]) w_ins = CB'(i + 1);
    end

    // lookup: first live entry with start<=q and end>=q, before the first start>q
    logic          w_hit;
    logic [IB-1:0] w_hit_pos;
    always_comb begin
        w_hit = 1'b0;
        w_hit_pos = '0;
        for (int i = sit_pkg::DEPTH - 1; i >= 0; i--)
            if (w_live[i] && w_sle[i] && w_ege[i]) begin
                w_hit = 1'b1;
                w_hit_pos = IB'(i);
            end
    end

    assign w_key = (r_cmd == sit_pkg::CMD_LOOKUP) ? r_query : r_new.start_ms;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);

    sit_chain u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_key     (w_key),
        .o_entries (w_entries),
        .o_start_le(w_sle),
        .o_end_ge  (w_ege)
    );

    sit_pkg::t_entry w_at;
    assign w_at = w_entries[r_idx];
    logic w_bad, w_full, w_same;
    assign w_bad  = CB'(r_idx) >= r_count;
    assign w_full = r_count == CB'(sit_pkg::DEPTH);
    assign w_same = w_at == r_new;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_mod    = r_mod;
        n_status = sit_pkg::ST_OK;
        n_pos    = '0;
        n_found  = '0;
        n_load   = 1'b0;
        w_ctl.op    = sit_pkg::OP_HOLD;
        w_ctl.pos   = '0;
        w_ctl.entry = r_new;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_load  = 1'b1;
                n_state = S_DONE;
                unique case (r_cmd)
                    sit_pkg::CMD_CLEAR: n_count = '0;
                    sit_pkg::CMD_INSERT: begin
                        if (w_full) n_status = sit_pkg::ST_FULL;
                        else begin
                            w_ctl.op  = sit_pkg::OP_OPEN;
                            w_ctl.pos = w_ins[IB-1:0];
                            n_pos     = w_ins[IB-1:0];
                            n_count   = r_count + 1'b1;
                            n_mod     = 1'b1;
                        end
                    end
                    sit_pkg::CMD_REMOVE: begin
                        if (w_bad) n_status = sit_pkg::ST_BAD_INDEX;
                        else begin
                            w_ctl.op  = sit_pkg::OP_CLOSE;
                            w_ctl.pos = r_idx;
                            n_pos     = r_idx;
                            n_count   = r_count - 1'b1;
                            n_mod     = 1'b1;
                        end
                    end
                    sit_pkg::CMD_REPLACE: begin
                        if (w_bad) n_status = sit_pkg::ST_BAD_INDEX;
                        else if (w_same) begin
                            n_status = sit_pkg::ST_UNCHANGED;
                            n_pos    = r_idx;
                        end else begin
                            w_ctl.op  = sit_pkg::OP_CLOSE;
                            w_ctl.pos = r_idx;
                            n_count   = r_count - 1'b1;
                            n_mod     = 1'b1;
                            n_load    = 1'b0;
                            n_state   = S_REINS;
                        end
                    end
                    sit_pkg::CMD_LOOKUP: begin
                        if (w_hit) begin
                            n_pos   = w_hit_pos;
                            n_found = w_entries[w_hit_pos];
                        end else n_status = sit_pkg::ST_NOT_FOUND;
                    end
                    default: ;
                endcase
            end
            S_REINS: begin
                w_ctl.op  = sit_pkg::OP_OPEN;
                w_ctl.pos = w_ins[IB-1:0];
                n_pos     = w_ins[IB-1:0];
                n_count   = r_count + 1'b1;
                n_load    = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_mod    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_mod   <= n_mod;
            if (n_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd          <= s_axis_tdata[2:0];
            r_idx          <= s_axis_tdata[8:3];
            r_new.start_ms <= s_axis_tdata[40:9];
            r_new.end_ms   <= s_axis_tdata[72:41];
            r_new.tag      <= s_axis_tdata[88:73];
            r_query        <= s_axis_tdata[120:89];
        end
        if (n_load) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_found  <= n_found;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_mod, r_count, r_found.tag, r_found.end_ms,
                            r_found.start_ms, r_pos, r_status};
endmodule

FILE: hw/rtl/sit_checker.sv
// Port-level checks for sorted_interval_table, bound to the top level.
// Depends on sit_pkg and sorted_interval_table.
module sit_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // count never exceeds depth
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:89] <= 7'd64)
        else $error("entry count above depth");
    // no new item the cycle after one is taken
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back to back accept");
    // a miss carries zero found fields
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == sit_pkg::ST_NOT_FOUND |-> m_axis_tdata[88:3] == '0)
        else $error("miss with nonzero fields");
endmodule

bind sorted_interval_table sit_checker u_sit_checker (.*);

FILE: verif/sorted_interval_table_tb.sv
// Self-checking bench for sorted_interval_table: directed and random edit and
// lookup traffic, results predicted by a behavioral table. Depends on sit_pkg.
module sorted_interval_table_tb;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    sorted_interval_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // fields from the highest bit down: status in the lowest bits
    typedef struct packed {
        logic        modified;
        logic [6:0]  count;
        logic [15:0] ftag;
        logic [31:0] fend;
        logic [31:0] fstart;
        logic [5:0]  position;
        logic [2:0]  status;
    } t_reply;

    // shadow table
    logic [31:0] tbl_start [sit_pkg::DEPTH];
    logic [31:0] tbl_end   [sit_pkg::DEPTH];
    logic [15:0] tbl_tag   [sit_pkg::DEPTH];
    int          tbl_count;
    logic        tbl_mod;

    t_reply pending_replies[$];
    int     errors = 0;
    int     cycles = 0;
    int     src_idle = 0;
    int     snk_stall = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int tbl_place(logic [31:0] s, logic [31:0] e, logic [15:0] t);
        int p;
        p = 0;
        while (p < tbl_count && tbl_start[p] <= s) p++;
        for (int i = tbl_count; i > p; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_end[i]   = tbl_end[i-1];
            tbl_tag[i]   = tbl_tag[i-1];
        end
        tbl_start[p] = s; tbl_end[p] = e; tbl_tag[p] = t;
        tbl_count++;
        tbl_mod = 1;
        return p;
    endfunction

    function automatic void tbl_drop(int p);
        for (int i = p; i + 1 < tbl_count; i++) begin
            tbl_start[i] = tbl_start[i+1];
            tbl_end[i]   = tbl_end[i+1];
            tbl_tag[i]   = tbl_tag[i+1];
        end
        tbl_count--;
        tbl_mod = 1;
    endfunction

    function automatic t_reply predict_reply(logic [127:0] d);
        t_reply r;
        logic [2:0]  c;
        int          idx;
        logic [31:0] s, e, q;
        logic [15:0] t;
        c = d[2:0]; idx = d[8:3]; s = d[40:9]; e = d[72:41]; t = d[88:73]; q = d[120:89];
        r = '0;
        r.status = sit_pkg::ST_OK;
        case (c)
            sit_pkg::CMD_CLEAR: tbl_count = 0;
            sit_pkg::CMD_INSERT: begin
                if (tbl_count >= sit_pkg::DEPTH) r.status = sit_pkg::ST_FULL;
                else r.position = 6'(tbl_place(s, e, t));
            end
            sit_pkg::CMD_REMOVE: begin
                if (idx >= tbl_count) r.status = sit_pkg::ST_BAD_INDEX;
                else begin
                    tbl_drop(idx);
                    r.position = 6'(idx);
                end
            end
            sit_pkg::CMD_REPLACE: begin
                if (idx >= tbl_count) r.status = sit_pkg::ST_BAD_INDEX;
                else if (tbl_start[idx] == s && tbl_end[idx] == e && tbl_tag[idx] == t) begin
                    r.status = sit_pkg::ST_UNCHANGED;
                    r.position = 6'(idx);
                end else begin
                    tbl_drop(idx);
                    r.position = 6'(tbl_place(s, e, t));
                end
            end
            sit_pkg::CMD_LOOKUP: begin
                r.status = sit_pkg::ST_NOT_FOUND;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_start[i] > q) break;
                    if (tbl_end[i] >= q) begin
                        r.status = sit_pkg::ST_OK;
                        r.position = 6'(i);
                        r.fstart = tbl_start[i];
                        r.fend = tbl_end[i];
                        r.ftag = tbl_tag[i];
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.count = 7'(tbl_count);
        r.modified = tbl_mod;
        return r;
    endfunction

    // send one item, honoring the sender idle rate; tvalid stays up between
    // back-to-back items and drops only while idling or in drain
    task automatic send_item(logic [2:0] c, int idx, logic [31:0] s, logic [31:0] e,
                             logic [15:0] t, logic [31:0] q);
        logic [127:0] d;
        d = '0;
        d[2:0] = c; d[8:3] = 6'(idx); d[40:9] = s; d[72:41] = e; d[88:73] = t;
        d[120:89] = q;
        d[127:121] = 7'($urandom);   // pad bits, should be ignored
        if ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        // tready is settled mid-cycle; the next rising edge takes the item
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        pending_replies.push_back(predict_reply(d));
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // times drawn close together so lookups and equal starts happen
    function automatic logic [31:0] rand_time();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'hFFFF_FFF0 + $urandom_range(15);
            default: return $urandom_range(200);
        endcase
    endfunction

    task automatic rand_item();
        int          w;
        int          idx;
        logic [2:0]  c;
        logic [31:0] s;
        w = $urandom_range(99);
        if (w < 35) c = sit_pkg::CMD_INSERT;
        else if (w < 50) c = sit_pkg::CMD_REMOVE;
        else if (w < 65) c = sit_pkg::CMD_REPLACE;
        else if (w < 93) c = sit_pkg::CMD_LOOKUP;
        else if (w < 95) c = sit_pkg::CMD_CLEAR;
        else c = 3'($urandom_range(5, 7));
        // mostly valid indexes, some past the end
        if (tbl_count > 0 && $urandom_range(9) < 8) idx = $urandom_range(tbl_count - 1);
        else idx = $urandom_range(63);
        s = rand_time();
        if (c == sit_pkg::CMD_REPLACE && idx < tbl_count && $urandom_range(3) == 0)
            send_item(c, idx, tbl_start[idx], tbl_end[idx], tbl_tag[idx], rand_time());
        else
            send_item(c, idx, s, ($urandom_range(3) == 0) ? rand_time() : s + $urandom_range(60),
                      16'($urandom), rand_time());
    endtask

    task automatic test_directed();
        send_item(sit_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0);               // empty lookup
        send_item(sit_pkg::CMD_REMOVE, 0, 0, 0, 0, 0);               // bad index on empty
        send_item(sit_pkg::CMD_REPLACE, 63, 0, 0, 0, 0);
        send_item(sit_pkg::CMD_INSERT, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0);
        send_item(sit_pkg::CMD_INSERT, 0, 0, 0, 0, 0);
        send_item(sit_pkg::CMD_INSERT, 0, 10, 20, 16'h1234, 0);
        send_item(sit_pkg::CMD_INSERT, 0, 10, 30, 16'h5678, 0);      // equal start keeps order
        send_item(sit_pkg::CMD_LOOKUP, 0, 0, 0, 0, 15);
        send_item(sit_pkg::CMD_LOOKUP, 0, 0, 0, 0, 25);
        send_item(sit_pkg::CMD_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(sit_pkg::CMD_LOOKUP, 0, 0, 0, 0, 5);               // miss
        send_item(sit_pkg::CMD_REPLACE, 1, 10, 20, 16'h1234, 0);     // identical
        send_item(sit_pkg::CMD_REPLACE, 1, 5, 40, 16'hAAAA, 0);      // changed
        send_item(sit_pkg::CMD_REMOVE, 3, 0, 0, 0, 0);
        send_item(sit_pkg::CMD_REMOVE, 4, 0, 0, 0, 0);               // bad index
        send_item(3'd5, 0, 0, 0, 0, 0);
        send_item(3'd7, 63, 1, 1, 1, 1);
        send_item(sit_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        // fill to full, then one more
        for (int i = 0; i < sit_pkg::DEPTH; i++)
            send_item(sit_pkg::CMD_INSERT, 0, $urandom_range(100), 200, 16'(i), 0);
        send_item(sit_pkg::CMD_INSERT, 0, 1, 2, 3, 0);
        send_item(sit_pkg::CMD_REMOVE, 63, 0, 0, 0, 0);
        send_item(sit_pkg::CMD_LOOKUP, 0, 0, 0, 0, 200);
        send_item(sit_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(int n, int src, int snk);
        src_idle = src;
        snk_stall = snk;
        for (int i = 0; i < n; i++) rand_item();
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(99) >= snk_stall);
    end

    // result check
    always @(posedge i_clk) begin
        t_reply exp_r, got;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[96:0];
            if (pending_replies.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (got.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                end
                if (got.position !== exp_r.position) begin
                    $error("position exp %0d got %0d", exp_r.position, got.position); errors++;
                end
                if (got.fstart !== exp_r.fstart) begin
                    $error("found_start exp %h got %h", exp_r.fstart, got.fstart); errors++;
                end
                if (got.fend !== exp_r.fend) begin
                    $error("found_end exp %h got %h", exp_r.fend, got.fend); errors++;
                end
                if (got.ftag !== exp_r.ftag) begin
                    $error("found_tag exp %h got %h", exp_r.ftag, got.ftag); errors++;
                end
                if (got.count !== exp_r.count) begin
                    $error("entry_count exp %0d got %0d", exp_r.count, got.count); errors++;
                end
                if (got.modified !== exp_r.modified) begin
                    $error("modified exp %0d got %0d", exp_r.modified, got.modified); errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        tbl_count = 0;
        tbl_mod = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random(330, 0, 0);
        drain();                       // sender holds off until all results are in
        test_random(330, 55, 0);
        test_random(330, 0, 55);
        test_random(330, 37, 37);
        drain();
        if (errors == 0 && pending_replies.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/sit_pkg.sv
hw/rtl/sit_cell.sv
hw/rtl/sit_chain.sv
hw/rtl/sorted_interval_table.sv
hw/rtl/sit_checker.sv
verif/sorted_interval_table_tb.sv
